FILE: rtl/aes_ctr_pkg.sv
package aes_ctr_pkg;

   localparam int DataWidth = 8;
   localparam int RegWidth = 64;
   localparam int CsrIndexWidth = 3;
   localparam int NumRounds = 14;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_3 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_IV_UPPER = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_IV_LOWER = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } core_ctl_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] tab [256];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
      };
      return tab[a];
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

endpackage

FILE: rtl/aes_ctr_if.sv
interface aes_ctr_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aes_ctr_csr_if #(parameter int IndexWidth = 3, parameter int Width = 64);
   logic                  valid;
   logic                  ready;
   logic [IndexWidth-1:0] index;
   logic [Width-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/aes_ctr_key_sched.sv
// On-the-fly AES-256 key schedule: holds a sliding 256-bit window and yields the
// round key of the current round; advances by eight words every second round.
module aes_ctr_key_sched (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic [255:0] key,
   input  logic         step,
   output logic [127:0] round_key
);
   import aes_ctr_pkg::*;

   logic [255:0] win_ff, win_in;
   logic         half_ff, half_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  t0, t1, n0, n1, n2, n3, t4, m0, m1, m2, m3;

   assign round_key = half_ff ? win_ff[127:0] : win_ff[255:128];

   always_comb begin
      t0 = win_ff[31:0];
      t1 = sbox_word({t0[23:0], t0[31:24]}) ^ {rcon_ff, 24'd0};
      n0 = win_ff[255:224] ^ t1;
      n1 = win_ff[223:192] ^ n0;
      n2 = win_ff[191:160] ^ n1;
      n3 = win_ff[159:128] ^ n2;
      t4 = sbox_word(n3);
      m0 = win_ff[127:96] ^ t4;
      m1 = win_ff[95:64] ^ m0;
      m2 = win_ff[63:32] ^ m1;
      m3 = win_ff[31:0] ^ m2;
      win_in = win_ff;
      half_in = half_ff;
      rcon_in = rcon_ff;
      if (load) begin
         win_in = key;
         half_in = 1'b0;
         rcon_in = 8'h01;
      end else if (step) begin
         half_in = ~half_ff;
         if (half_ff) begin
            win_in = {n0, n1, n2, n3, m0, m1, m2, m3};
            rcon_in = gf_double(rcon_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         half_ff <= 1'b0;
         rcon_ff <= 8'h01;
      end else begin
         half_ff <= half_in;
         rcon_ff <= rcon_in;
      end
   end

endmodule

FILE: rtl/aes_ctr_round.sv
// One shared AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes_ctr_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         last,
   output logic [127:0] state_out
);
   import aes_ctr_pkg::*;

   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_in[127-8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4+r] = sbox(s[((c+r)%4)*4+r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         m[c*4]   = t[c*4]   ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ gf_double(t[c*4]^t[c*4+1]);
         m[c*4+1] = t[c*4+1] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ gf_double(t[c*4+1]^t[c*4+2]);
         m[c*4+2] = t[c*4+2] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ gf_double(t[c*4+2]^t[c*4+3]);
         m[c*4+3] = t[c*4+3] ^ (t[c*4]^t[c*4+1]^t[c*4+2]^t[c*4+3]) ^ gf_double(t[c*4+3]^t[c*4]);
      end
      for (int i = 0; i < 16; i++) begin
         state_out[127-8*i -: 8] = (last ? t[i] : m[i]) ^ round_key[127-8*i -: 8];
      end
   end

endmodule

FILE: rtl/aes256_ctr_byte_cipher.sv
// Channel  | Dir | Payload
// req      | in  | data_in (8 bits)
// rsp      | out | data_out (8 bits)
// csr      | in  | index (3 bits), data (64 bits)
// A byte at keystream position 1..15 is XORed with the stored keystream on
// accept; its result is valid in the next cycle. At position 0 the shared round
// unit runs the initial key add plus 14 rounds. Each rsp transaction returns the
// block to idle. Reset and csr writes to index 0..5 reload the key, the counter
// and clear the position. req is held off while a result waits on rsp.
module aes256_ctr_byte_cipher (
   input logic clock,
   input logic reset,
   aes_ctr_stream_if.sink   req,
   aes_ctr_stream_if.source rsp,
   aes_ctr_csr_if.sink      csr
);
   import aes_ctr_pkg::*;

   logic [RegWidth-1:0] key_ff [4];
   logic [RegWidth-1:0] iv_ff [2];
   logic [127:0] ctr_ff, ctr_in;
   logic [127:0] ks_ff, ks_in;
   logic [127:0] st_ff, st_in;
   logic [3:0]   pos_ff, pos_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [7:0]   din_ff, din_in;
   logic [7:0]   dout_ff, dout_in;
   state_type    state_ff, state_in;
   core_ctl_type ctl;
   logic         wr, reload, ks_step;
   logic [127:0] rk, round_out;

   assign wr = csr.valid & csr.ready;
   assign csr.ready = (state_ff == ST_IDLE);
   assign reload = wr & (csr.index <= CSR_IV_LOWER);

   aes_ctr_key_sched u_ks (
      .clock(clock), .reset(reset),
      .load(reload | reset | ctl.start),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .step(ks_step), .round_key(rk)
   );

   aes_ctr_round u_round (
      .state_in(st_ff), .round_key(rk), .last(rnd_ff == 4'(NumRounds)),
      .state_out(round_out)
   );

   always_comb begin
      ctl.start = req.valid & req.ready & (pos_ff == 4'd0);
      ctl.busy = (state_ff == ST_ROUND);
      ctl.done = ctl.busy & (rnd_ff == 4'(NumRounds));
      ks_step = ctl.busy;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid & req.ready) state_in = (pos_ff == 4'd0) ? ST_ROUND : ST_OUT;
         end
         ST_ROUND: begin
            if (ctl.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == ST_IDLE) & ~csr.valid;
      rsp.valid = (state_ff == ST_OUT);
      rsp.data = dout_ff;
   end

   always_comb begin
      ctr_in = ctr_ff;
      ks_in = ks_ff;
      st_in = st_ff;
      pos_in = pos_ff;
      rnd_in = rnd_ff;
      din_in = din_ff;
      dout_in = dout_ff;
      if (req.valid & req.ready) begin
         din_in = req.data;
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'd0) begin
            st_in = ctr_ff;
            rnd_in = 4'd0;
            ctr_in = ctr_ff + 128'd1;
         end else begin
            dout_in = req.data ^ ks_ff[127 - 8*pos_ff -: 8];
         end
      end
      if (ctl.busy) begin
         // round 0 is the plain whitening key add
         st_in = (rnd_ff == 4'd0) ? (st_ff ^ rk) : round_out;
         rnd_in = rnd_ff + 4'd1;
         if (ctl.done) begin
            ks_in = round_out;
            dout_in = din_ff ^ round_out[127:120];
         end
      end
      if (reload) begin
         ctr_in = (csr.index == CSR_IV_UPPER) ? {csr.data, iv_ff[1]} :
                  (csr.index == CSR_IV_LOWER) ? {iv_ff[0], csr.data} :
                  {iv_ff[0], iv_ff[1]};
         pos_in = 4'd0;
         ks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      din_ff <= din_in;
      dout_ff <= dout_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         iv_ff[0] <= '0;
         iv_ff[1] <= '0;
         ctr_ff <= '0;
         ks_ff <= '0;
         pos_ff <= 4'd0;
         rnd_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         ks_ff <= ks_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
         if (wr) begin
            unique case (csr.index)
               CSR_KEY_0: key_ff[0] <= csr.data;
               CSR_KEY_1: key_ff[1] <= csr.data;
               CSR_KEY_2: key_ff[2] <= csr.data;
               CSR_KEY_3: key_ff[3] <= csr.data;
               CSR_IV_UPPER: iv_ff[0] <= csr.data;
               CSR_IV_LOWER: iv_ff[1] <= csr.data;
               default: ;
            endcase
         end
      end
   end

endmodule
